// File: rtl/indexed_list_engine_assert.svh
// Assertion macros used by the port-level checker of the indexed list engine.
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define ILE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("indexed list engine check failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define ILE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("indexed list engine check failed");

`endif

// File: rtl/ile_pkg.sv
// Shared types, codes and functions of the indexed list engine.
package ile_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int WORD_W    = 64;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    REQ_APPEND = 3'd0,
    REQ_READ   = 3'd1,
    REQ_WRITE  = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_INSERT = 3'd4,
    REQ_CLEAR  = 3'd5,
    REQ_SEARCH = 3'd6
  } req_kind_t;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [5:0]        position;
    logic [WORD_W-1:0] item_word;
  } ile_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    logic              found;
    logic [6:0]        entry_count;
    logic [1:0]        status;
  } ile_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RD_WAIT,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_INS_PUT,
    S_SEARCH,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_POS,
    IDX_COUNT,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_POS,
    RD_NEXT,
    RD_PREV,
    RD_IDX
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_APPEND,
    WR_POS,
    WR_BELOW,
    WR_ABOVE
  } wr_sel_t;

  typedef struct packed {
    logic       capture;
    cnt_op_t    cnt_op;
    idx_op_t    idx_op;
    rd_sel_t    rd_sel;
    wr_sel_t    wr_sel;
    logic       cmp_en;
    logic       take_rd;
    logic       st_load;
    logic [1:0] st_value;
    logic       load_out;
  } ile_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       pos_lt_cnt;
    logic       pos_gt_cnt;
    logic       full;
    logic       next_lt_cnt;
    logic       idx_gt_pos;
    logic       idx_lt_cnt;
  } ile_sts_t;

  // IEEE equality on double bit patterns: signed zeros match, NaN matches nothing.
  function automatic logic ieee_equal(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
    logic a_nan;
    logic b_nan;
    logic both_zero;
    a_nan     = a[62:0] > 63'h7FF0000000000000;
    b_nan     = b[62:0] > 63'h7FF0000000000000;
    both_zero = (a[62:0] | b[62:0]) == 63'd0;
    return !a_nan && !b_nan && (both_zero || (a == b));
  endfunction

endpackage

// File: rtl/ile_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ile_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/ile_ctrl.sv
// Controller state machine of the indexed list engine.
module ile_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  input  ile_pkg::ile_sts_t sts,
  output ile_pkg::ile_cmd_t cmd
);
  import ile_pkg::*;

  state_t state;
  state_t state_next;
  logic   pend;
  logic   pend_next;
  logic   rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pend      <= pend_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = S_FINISH;
        case (sts.kind)
          REQ_READ: begin
            if (sts.pos_lt_cnt) begin
              state_next = S_RD_WAIT;
            end
          end
          REQ_REMOVE: begin
            if (sts.pos_lt_cnt) begin
              state_next = S_SHIFT_DN;
            end
          end
          REQ_INSERT: begin
            if (!sts.pos_gt_cnt && !sts.full) begin
              state_next = S_SHIFT_UP;
            end
          end
          REQ_SEARCH: state_next = S_SEARCH;
          default: state_next = S_FINISH;
        endcase
      end
      S_RD_WAIT: state_next = S_FINISH;
      S_SHIFT_DN: begin
        if (!sts.next_lt_cnt) begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT_UP: begin
        if (!sts.idx_gt_pos) begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: state_next = S_FINISH;
      S_SEARCH: begin
        if (!sts.idx_lt_cnt) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    pend_next = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready   = !rst;
        cmd.capture = req_valid && !rst;
      end
      S_CHECK: begin
        case (sts.kind)
          REQ_APPEND: begin
            if (sts.full) begin
              cmd.st_load  = 1'b1;
              cmd.st_value = ST_FULL;
            end else begin
              cmd.wr_sel = WR_APPEND;
              cmd.cnt_op = CNT_INC;
            end
          end
          REQ_READ: begin
            if (sts.pos_lt_cnt) begin
              cmd.rd_sel = RD_POS;
            end else begin
              cmd.st_load  = 1'b1;
              cmd.st_value = ST_RANGE;
            end
          end
          REQ_WRITE: begin
            if (sts.pos_lt_cnt) begin
              cmd.wr_sel = WR_POS;
            end else begin
              cmd.st_load  = 1'b1;
              cmd.st_value = ST_RANGE;
            end
          end
          REQ_REMOVE: begin
            if (sts.pos_lt_cnt) begin
              cmd.idx_op = IDX_POS;
            end else begin
              cmd.st_load  = 1'b1;
              cmd.st_value = ST_RANGE;
            end
          end
          REQ_INSERT: begin
            if (sts.pos_gt_cnt) begin
              cmd.st_load  = 1'b1;
              cmd.st_value = ST_RANGE;
            end else if (sts.full) begin
              cmd.st_load  = 1'b1;
              cmd.st_value = ST_FULL;
            end else begin
              cmd.idx_op = IDX_COUNT;
            end
          end
          REQ_CLEAR: cmd.cnt_op = CNT_CLR;
          REQ_SEARCH: cmd.idx_op = IDX_ZERO;
          default: cmd.st_load = 1'b0;
        endcase
      end
      S_RD_WAIT: cmd.take_rd = 1'b1;
      S_SHIFT_DN: begin
        if (sts.next_lt_cnt) begin
          cmd.rd_sel = RD_NEXT;
          cmd.idx_op = IDX_INC;
        end else begin
          cmd.cnt_op = CNT_DEC;
        end
        if (pend) begin
          cmd.wr_sel = WR_BELOW;
        end
        pend_next = sts.next_lt_cnt;
      end
      S_SHIFT_UP: begin
        if (sts.idx_gt_pos) begin
          cmd.rd_sel = RD_PREV;
          cmd.idx_op = IDX_DEC;
        end
        if (pend) begin
          cmd.wr_sel = WR_ABOVE;
        end
        pend_next = sts.idx_gt_pos;
      end
      S_INS_PUT: begin
        cmd.wr_sel = WR_POS;
        cmd.cnt_op = CNT_INC;
      end
      S_SEARCH: begin
        if (sts.idx_lt_cnt) begin
          cmd.rd_sel = RD_IDX;
          cmd.idx_op = IDX_INC;
        end
        cmd.cmp_en = pend;
        pend_next  = sts.idx_lt_cnt;
      end
      S_FINISH: cmd.load_out = !rsp_valid || rsp_ready;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

endmodule

// File: rtl/ile_datapath.sv
// Datapath of the indexed list engine: entry RAM, count, walk index and result register.
module ile_datapath #(
  parameter int DEPTH = ile_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ile_pkg::ile_req_t req,
  input  ile_pkg::ile_cmd_t cmd,
  output ile_pkg::ile_sts_t sts,
  output ile_pkg::ile_rsp_t rsp
);
  import ile_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 6) ? CW : 6;
  localparam logic [CW-1:0] ONE = CW'(1);

  ile_req_t          req_q;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     idx_next;
  logic              hit;
  logic [WORD_W-1:0] rd_word;
  logic [1:0]        st;

  logic [CW-1:0]     idx_up;
  logic [CW-1:0]     idx_dn;
  logic [CW:0]       idx_up_w;
  logic [CMPW-1:0]   pos_x;
  logic [CMPW-1:0]   cnt_x;
  logic [CMPW-1:0]   idx_x;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [WORD_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [WORD_W-1:0] ram_rd_data;

  assign idx_up   = idx + ONE;
  assign idx_dn   = idx - ONE;
  assign idx_up_w = {1'b0, idx} + {{CW{1'b0}}, 1'b1};
  assign pos_x    = CMPW'(req_q.position);
  assign cnt_x    = CMPW'(count);
  assign idx_x    = CMPW'(idx);

  always_comb begin
    sts             = '0;
    sts.kind        = req_q.req_type;
    sts.pos_lt_cnt  = pos_x < cnt_x;
    sts.pos_gt_cnt  = pos_x > cnt_x;
    sts.full        = count == CW'(DEPTH);
    sts.next_lt_cnt = idx_up_w < {1'b0, count};
    sts.idx_gt_pos  = idx_x > pos_x;
    sts.idx_lt_cnt  = idx < count;
  end

  always_comb begin
    ram_wr_en   = cmd.wr_sel != WR_NONE;
    ram_wr_addr = '0;
    ram_wr_data = ram_rd_data;
    case (cmd.wr_sel)
      WR_APPEND: begin
        ram_wr_addr = count[AW-1:0];
        ram_wr_data = req_q.item_word;
      end
      WR_POS: begin
        ram_wr_addr = pos_x[AW-1:0];
        ram_wr_data = req_q.item_word;
      end
      WR_BELOW: ram_wr_addr = idx_dn[AW-1:0];
      WR_ABOVE: ram_wr_addr = idx_up[AW-1:0];
      default: ram_wr_addr = '0;
    endcase
  end

  always_comb begin
    ram_rd_en   = cmd.rd_sel != RD_NONE;
    ram_rd_addr = '0;
    case (cmd.rd_sel)
      RD_POS:  ram_rd_addr = pos_x[AW-1:0];
      RD_NEXT: ram_rd_addr = idx_up[AW-1:0];
      RD_PREV: ram_rd_addr = idx_dn[AW-1:0];
      RD_IDX:  ram_rd_addr = idx[AW-1:0];
      default: ram_rd_addr = '0;
    endcase
  end

  ile_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: count_next = count + ONE;
      CNT_DEC: count_next = count - ONE;
      CNT_CLR: count_next = '0;
      default: count_next = count;
    endcase
  end

  always_comb begin
    case (cmd.idx_op)
      IDX_POS:   idx_next = pos_x[CW-1:0];
      IDX_COUNT: idx_next = count;
      IDX_ZERO:  idx_next = '0;
      IDX_INC:   idx_next = idx_up;
      IDX_DEC:   idx_next = idx_dn;
      default:   idx_next = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (cmd.capture) begin
      req_q   <= req;
      hit     <= 1'b0;
      rd_word <= '0;
      st      <= ST_OK;
    end else begin
      if (cmd.cmp_en && ieee_equal(ram_rd_data, req_q.item_word)) begin
        hit <= 1'b1;
      end
      if (cmd.take_rd) begin
        rd_word <= ram_rd_data;
      end
      if (cmd.st_load) begin
        st <= cmd.st_value;
      end
    end
    if (cmd.load_out) begin
      rsp.read_word   <= rd_word;
      rsp.found       <= hit;
      rsp.entry_count <= 7'(count);
      rsp.status      <= st;
    end
  end

endmodule

// File: rtl/indexed_list_engine.sv
// Top level of the indexed list engine: an ordered list of double words with a count.
//
// A request transaction on req (req_valid/req_ready) carries req_type, position and
// item_word; each request produces exactly one response transaction on rsp
// (rsp_valid/rsp_ready) with read_word, found, entry_count and status.
// Requests are handled one at a time: req_ready is high only while the engine is idle.
// Remove and insert walk the entries from the position to the end of the list; search
// walks every stored entry. The other request types do no walk.
// The walk over stored entries is bound by the single read and single write port of
// the entry RAM, one entry per cycle.
// The response sits in an output register, so the next request is accepted while an
// earlier response still waits; if the receiver stalls, the following request runs
// to completion and then holds until the response register is free.
// Synchronous reset empties the list (count zero) and drops any pending response;
// RAM contents are not cleared and need no clearing pass.
module indexed_list_engine #(
  parameter int DEPTH = ile_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  ile_pkg::ile_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output ile_pkg::ile_rsp_t rsp
);
  import ile_pkg::*;

  ile_cmd_t cmd;
  ile_sts_t sts;

  ile_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ile_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

// File: rtl/ile_checker.sv
// Port-level assertion checker for the indexed list engine, bound to the top level.
`include "indexed_list_engine_assert.svh"

module ile_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input ile_pkg::ile_req_t req,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input ile_pkg::ile_rsp_t rsp
);
  import ile_pkg::*;

  `ILE_ASSERT_NOW(a_status_code, rsp_valid, rsp.status != 2'd3)
  `ILE_ASSERT_NOW(a_error_zero, rsp_valid && (rsp.status != ST_OK), (rsp.read_word == '0) && !rsp.found)
  `ILE_ASSERT_NOW(a_found_clean, rsp_valid && rsp.found, (rsp.status == ST_OK) && (rsp.read_word == '0))
  `ILE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind indexed_list_engine ile_checker u_ile_checker (.*);
